[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the RTL, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[src/tpp_pkg.sv]
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the terminal output post-processing unit.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int COLUMN_WIDTH = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 3;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7f;
    localparam logic [7:0] UTF8_CONT_MASK = 8'hc0;
    localparam logic [7:0] UTF8_CONT_CODE = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POST_ENABLE   = 3'd0,
        CFG_NL_TO_CRNL    = 3'd1,
        CFG_NL_RETURNS    = 3'd2,
        CFG_NO_CR_AT_COL0 = 3'd3,
        CFG_CR_TO_NL      = 3'd4,
        CFG_TAB_EXPAND    = 3'd5,
        CFG_UTF8_MODE     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic post_enable;
        logic nl_to_crnl;
        logic nl_returns;
        logic no_cr_at_col0;
        logic cr_to_nl;
        logic tab_expand;
        logic utf8_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_CRNL   = 2'd1,
        OP_SPACES = 2'd2
    } op_t;

    // cnt holds the number of spaces minus one for OP_SPACES
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [2:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[src/tpp_if.sv]
// ----------------------------------------------------------------------------
// tpp_if
// Valid/ready channel interfaces: input bytes, output bytes, config writes.
// ----------------------------------------------------------------------------
interface tpp_byte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface tpp_byte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface tpp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/tpp_front.sv]
// ----------------------------------------------------------------------------
// tpp_front
// Accepts input bytes, classifies them, tracks the cursor column and
// pushes one command per surviving byte into the queue.
// ----------------------------------------------------------------------------
module tpp_front (
    input  logic          clk,
    input  logic          rst_n,
    tpp_byte_in_if.sink   char_ch,
    input  tpp_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          q_push,
    output tpp_pkg::cmd_t q_cmd
);
    import tpp_pkg::*;

    logic [COLUMN_WIDTH-1:0] col_reg;
    logic [COLUMN_WIDTH-1:0] col_next;
    logic                    drop;
    logic                    accept;
    logic                    printable;

    assign char_ch.ready = !q_full;
    assign accept        = char_ch.valid && char_ch.ready;
    assign q_push        = accept && !drop;

    assign printable = (char_ch.in_byte >= CH_SP) && (char_ch.in_byte != CH_DEL)
        && (!cfg.utf8_mode || ((char_ch.in_byte & UTF8_CONT_MASK) != UTF8_CONT_CODE));

    always_comb
    begin
        drop       = 1'b0;
        q_cmd.op   = OP_BYTE;
        q_cmd.data = char_ch.in_byte;
        q_cmd.cnt  = 3'd0;
        col_next   = col_reg;
        if (cfg.post_enable)
        begin
            unique case (char_ch.in_byte)
                CH_NL:
                begin
                    if (cfg.nl_to_crnl)
                    begin
                        q_cmd.op = OP_CRNL;
                        col_next = '0;
                    end
                    else if (cfg.nl_returns)
                    begin
                        col_next = '0;
                    end
                end
                CH_CR:
                begin
                    if (cfg.no_cr_at_col0 && (col_reg == '0))
                    begin
                        drop = 1'b1;
                    end
                    else if (cfg.cr_to_nl)
                    begin
                        q_cmd.data = CH_NL;
                        if (cfg.nl_returns)
                        begin
                            col_next = '0;
                        end
                    end
                    else
                    begin
                        col_next = '0;
                    end
                end
                CH_TAB:
                begin
                    col_next = {col_reg[COLUMN_WIDTH-1:3] + 1'b1, 3'b000};
                    if (cfg.tab_expand)
                    begin
                        q_cmd.op   = OP_SPACES;
                        q_cmd.data = CH_SP;
                        q_cmd.cnt  = ~col_reg[2:0];
                    end
                end
                CH_BS:
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                default:
                begin
                    if (printable)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
        end
    end

endmodule

[src/tpp_queue.sv]
// ----------------------------------------------------------------------------
// tpp_queue
// Short command FIFO between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module tpp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tpp_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output tpp_pkg::cmd_t    head,
    output tpp_pkg::q_stat_t stat
);
    import tpp_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/tpp_back.sv]
// ----------------------------------------------------------------------------
// tpp_back
// Expands queued commands into output bytes, one per cycle while term_ch is
// ready, through a registered output stage.
// ----------------------------------------------------------------------------
module tpp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tpp_pkg::cmd_t  head,
    input  logic           q_empty,
    output logic           q_pop,
    tpp_byte_out_if.source term_ch
);
    import tpp_pkg::*;

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [7:0] byte_sel;
    logic       last_sel;
    logic       load;

    always_comb
    begin
        unique case (head.op)
            OP_CRNL:
            begin
                byte_sel = (idx_reg == '0) ? CH_CR : CH_NL;
                last_sel = (idx_reg != '0);
            end
            OP_SPACES:
            begin
                byte_sel = CH_SP;
                last_sel = (idx_reg == head.cnt);
            end
            default:
            begin
                byte_sel = head.data;
                last_sel = 1'b1;
            end
        endcase
    end

    assign load       = !q_empty && (!valid_reg || term_ch.ready);
    assign q_pop      = load && last_sel;
    assign idx_next   = load ? (last_sel ? 3'd0 : idx_reg + 3'd1) : idx_reg;
    assign valid_next = load || (valid_reg && !term_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_sel;
            last_reg <= last_sel;
        end
    end

    assign term_ch.valid    = valid_reg;
    assign term_ch.out_byte = byte_reg;
    assign term_ch.run_last = last_reg;

endmodule

[src/tty_output_postprocess_unit.sv]
// ----------------------------------------------------------------------------
// tty_output_postprocess_unit
// Terminal output post-processing: newline/CR translation, tab expansion
// and cursor column tracking.
// ----------------------------------------------------------------------------
// Usage:
//   char_ch  carries raw bytes in; term_ch carries translated bytes out with
//   run_last marking the final byte caused by one input byte. cfg_ch writes
//   the 1-bit mode registers (index 0..6, others ignored); it is always ready.
// Timing:
//   A byte accepted on char_ch is written into the command queue, then
//   loaded into the output register, from which it transfers on term_ch.
//   The emitter produces one output byte per cycle while term_ch is ready;
//   an input byte gives 0..8 output bytes, and the input keeps flowing at
//   one byte per cycle until the two-entry command queue fills. Single-byte
//   traffic runs at one byte per cycle while term_ch is ready.
// Reset:
//   Clears the column, the queue and the output stage; registers return to
//   post-processing on, NL as CR NL, all other modes off.
// Stall:
//   While term_ch is not ready the output byte holds; the queue then fills
//   and char_ch drops ready until space frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tty_output_postprocess_unit (
    input  logic           clk,
    input  logic           rst_n,
    tpp_byte_in_if.sink    char_ch,
    tpp_byte_out_if.source term_ch,
    tpp_cfg_if.sink        cfg_ch
);
    import tpp_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    cmd_t    push_cmd;
    cmd_t    head;
    logic    q_push;
    logic    q_pop;
    q_stat_t q_stat;

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                CFG_POST_ENABLE:   cfg_next.post_enable   = cfg_ch.data;
                CFG_NL_TO_CRNL:    cfg_next.nl_to_crnl    = cfg_ch.data;
                CFG_NL_RETURNS:    cfg_next.nl_returns    = cfg_ch.data;
                CFG_NO_CR_AT_COL0: cfg_next.no_cr_at_col0 = cfg_ch.data;
                CFG_CR_TO_NL:      cfg_next.cr_to_nl      = cfg_ch.data;
                CFG_TAB_EXPAND:    cfg_next.tab_expand    = cfg_ch.data;
                CFG_UTF8_MODE:     cfg_next.utf8_mode     = cfg_ch.data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.post_enable   <= 1'b1;
            cfg_reg.nl_to_crnl    <= 1'b1;
            cfg_reg.nl_returns    <= 1'b0;
            cfg_reg.no_cr_at_col0 <= 1'b0;
            cfg_reg.cr_to_nl      <= 1'b0;
            cfg_reg.tab_expand    <= 1'b0;
            cfg_reg.utf8_mode     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_ch),
        .cfg     (cfg_reg),
        .q_full  (q_stat.full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    tpp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .stat     (q_stat)
    );

    tpp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_stat.empty),
        .q_pop   (q_pop),
        .term_ch (term_ch)
    );

    `ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, q_push, !q_stat.full)
    `ASSERT_IMPLY(a_no_pop_when_empty, clk, rst_n, q_pop, !q_stat.empty)
    `ASSERT_NEXT(a_push_fills_queue, clk, rst_n, q_push && !q_pop, !q_stat.empty)

endmodule
